[hdl/vws_pkg.sv]
// types, constants and helpers shared by the validity window selector
`timescale 1ns / 1ps

package vws_pkg;

	localparam int TIME_W          = 48;
	localparam int IDX_W           = 8;
	localparam int TOL_W           = 32;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 32;
	localparam int MAX_ENTRIES_DEF = 256;

	localparam logic [1:0] OUTCOME_CONTAIN = 2'd0;
	localparam logic [1:0] OUTCOME_NEAREST = 2'd1;
	localparam logic [1:0] OUTCOME_NONE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SLOPPY    = CFG_IDX_W'(1);

	typedef struct packed {
		logic [TIME_W-1:0] query_time;
		logic [TIME_W-1:0] window_start;
		logic [TIME_W-1:0] window_end;
		logic              last_entry;
	} vws_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  chosen_index;
		logic [1:0]        outcome;
		logic [TIME_W-1:0] edge_distance;
	} vws_out_t;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance;
		logic             sloppy_mode;
	} vws_cfg_t;

	function automatic logic [TIME_W-1:0] vws_absdiff(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic vws_close(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b, input logic [TOL_W-1:0] tol);
		return vws_absdiff(a, b) <= TIME_W'(tol);
	endfunction

endpackage

[hdl/vws_track.sv]
// running best-window tracker: one registered word per cycle while step is set, against the current pick
`timescale 1ns / 1ps

module vws_track import vws_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  vws_in_t  entry,
	input  vws_cfg_t cfg,
	output vws_out_t result
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IW    = $clog2(MAX_ENTRIES);

	logic [CNT_W-1:0]  count_q, count_nxt;
	logic              found_q, found_nxt;
	logic [IW-1:0]     cidx_q, cidx_nxt;
	logic [TIME_W-1:0] cstart_q, cstart_nxt;
	logic [TIME_W-1:0] cend_q, cend_nxt;
	logic [IW-1:0]     nidx_q, nidx_nxt;
	logic [TIME_W-1:0] ndist_q, ndist_nxt;

	logic              in_range;
	logic [IW-1:0]     idx;
	logic [TIME_W-1:0] ds, de, d;
	logic              eligible, take;
	logic [IW+IDX_W-1:0] cidx_ext, nidx_ext;

	assign in_range = count_q < CNT_W'(MAX_ENTRIES);
	assign idx      = count_q[IW-1:0];
	assign ds       = vws_absdiff(entry.query_time, entry.window_start);
	assign de       = vws_absdiff(entry.query_time, entry.window_end);
	assign d        = (ds < de) ? ds : de;
	assign eligible = (entry.window_start <= entry.query_time)
		&& (entry.query_time < entry.window_end);

	always_comb begin
		if (!found_q) begin
			take = 1'b1;
		end else if (vws_close(entry.window_start, cstart_q, cfg.tolerance)) begin
			take = (entry.window_end > cend_q)
				|| vws_close(entry.window_end, cend_q, cfg.tolerance);
		end else begin
			take = entry.window_start > cstart_q;
		end
	end

	always_comb begin
		count_nxt  = count_q;
		found_nxt  = found_q;
		cidx_nxt   = cidx_q;
		cstart_nxt = cstart_q;
		cend_nxt   = cend_q;
		nidx_nxt   = nidx_q;
		ndist_nxt  = ndist_q;
		if (in_range) begin
			if (eligible && take) begin
				found_nxt  = 1'b1;
				cidx_nxt   = idx;
				cstart_nxt = entry.window_start;
				cend_nxt   = entry.window_end;
			end
			if (d <= ndist_q) begin
				nidx_nxt  = idx;
				ndist_nxt = d;
			end
			count_nxt = count_q + CNT_W'(1);
		end
	end

	assign cidx_ext = {{IDX_W{1'b0}}, cidx_nxt};
	assign nidx_ext = {{IDX_W{1'b0}}, nidx_nxt};

	always_comb begin
		if (found_nxt) begin
			result.chosen_index  = cidx_ext[IDX_W-1:0];
			result.outcome       = OUTCOME_CONTAIN;
			result.edge_distance = '0;
		end else if (cfg.sloppy_mode) begin
			result.chosen_index  = nidx_ext[IDX_W-1:0];
			result.outcome       = OUTCOME_NEAREST;
			result.edge_distance = ndist_nxt;
		end else begin
			result.chosen_index  = '0;
			result.outcome       = OUTCOME_NONE;
			result.edge_distance = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			found_q  <= 1'b0;
			cidx_q   <= '0;
			cstart_q <= '0;
			cend_q   <= '0;
			nidx_q   <= '0;
			ndist_q  <= '1;
		end else if (step) begin
			if (entry.last_entry) begin
				count_q  <= '0;
				found_q  <= 1'b0;
				cidx_q   <= '0;
				cstart_q <= '0;
				cend_q   <= '0;
				nidx_q   <= '0;
				ndist_q  <= '1;
			end else begin
				count_q  <= count_nxt;
				found_q  <= found_nxt;
				cidx_q   <= cidx_nxt;
				cstart_q <= cstart_nxt;
				cend_q   <= cend_nxt;
				nidx_q   <= nidx_nxt;
				ndist_q  <= ndist_nxt;
			end
		end
	end

endmodule

[hdl/validity_window_selector.sv]
// top level of the validity window selector: handshake, config registers, result register
`timescale 1ns / 1ps

// Picks one entry from a run of validity windows for a query time. Entries come in one word
// per clock when not stalled; a run ends on the word whose last_entry bit is set and that word
// gives one result word on the result port through the input register, which feeds the tracker,
// and the result register; other words give none. The block takes one word every cycle unless
// stalled, a figure set only by the combinational compare of a word against the registered
// running pick in the tracker. It stalls only when a closing word is waiting and the result
// register is still held by a stalled result. Entries past MAX_ENTRIES in a run are ignored
// but their last_entry bit still closes the run. tolerance and sloppy_mode must be written
// through the config port only while no word is in flight; the block does not enforce it.

module validity_window_selector import vws_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  entry_valid,
	output logic                  entry_stall,
	input  vws_in_t               entry,
	output logic                  result_valid,
	input  logic                  result_stall,
	output vws_out_t              result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic     valid_s1;
	vws_in_t  entry_s1;
	logic     result_valid_q;
	vws_out_t result_q;
	vws_cfg_t cfg_q;
	vws_out_t track_result;
	logic     out_free, advance, step, load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance   <= '0;
			cfg_q.sloppy_mode <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOLERANCE: cfg_q.tolerance <= cfg_data[TOL_W-1:0];
				REG_SLOPPY:    cfg_q.sloppy_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free    = !result_valid_q || !result_stall;
	assign advance     = !valid_s1 || !entry_s1.last_entry || out_free;
	assign entry_stall = !advance;
	assign step        = valid_s1 && advance;
	assign load        = step && entry_s1.last_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && entry_valid) begin
			entry_s1 <= entry;
		end
	end

	vws_track #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_track (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.entry (entry_s1),
		.cfg   (cfg_q),
		.result(track_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= track_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// stall only comes from a closing word blocked by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		entry_stall |-> valid_s1 && entry_s1.last_entry && result_valid_q && result_stall)
		else $error("entry stall without a blocked closing word");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.outcome == OUTCOME_CONTAIN
			|| result.outcome == OUTCOME_NEAREST || result.outcome == OUTCOME_NONE))
		else $error("result outcome out of range");

	a_distance_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.outcome != OUTCOME_NEAREST |-> result.edge_distance == '0)
		else $error("edge distance set outside nearest fallback");

	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.outcome == OUTCOME_NONE |-> result.chosen_index == '0)
		else $error("index set with no window found");

endmodule
